[rtl/bpa_pkg.sv]
// shared constants, types and helpers of the bitmap page allocator
package bpa_pkg;

	localparam int PAGE_COUNT_DEF = 32768;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam logic [15:0] LIMIT_RST = 16'd32768;
	localparam logic [46:0] BASE_RST  = 47'h000001000000;

	localparam logic [27:0] FREE_MAX = 28'hFFFFFFF;
	localparam logic [15:0] USED_MAX = 16'hFFFF;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_OOM     = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_BASE  = 1'b1;

	typedef struct packed {
		logic map_rd;
		logic map_wr;
		logic sum_rd;
		logic sum_wr;
	} mem_ctl_t;

	function automatic int addr_bits(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic logic [5:0] low_zero(input logic [63:0] w);
		logic [5:0] p;
		p = '0;
		for (int i = 63; i >= 0; i--) begin
			if (!w[i]) begin
				p = 6'(i);
			end
		end
		return p;
	endfunction

endpackage

[rtl/bpa_mem.sv]
// page map and full-word summary memories, registered read
module bpa_mem #(
	parameter int MAP_WORDS = 512,
	parameter int SUM_ROWS = 8,
	localparam int MAP_AW = bpa_pkg::addr_bits(MAP_WORDS),
	localparam int SUM_AW = bpa_pkg::addr_bits(SUM_ROWS)
) (
	input  logic                clk,
	input  bpa_pkg::mem_ctl_t   ctl,
	input  logic [MAP_AW-1:0]   map_addr,
	input  logic [63:0]         map_wdata,
	output logic [63:0]         map_rdata,
	input  logic [SUM_AW-1:0]   sum_addr,
	input  logic [63:0]         sum_wdata,
	output logic [63:0]         sum_rdata
);

	logic [63:0] map_mem [MAP_WORDS];
	logic [63:0] sum_mem [SUM_ROWS];
	logic [63:0] map_rd_q;
	logic [63:0] sum_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.map_wr) begin
			map_mem[map_addr] <= map_wdata;
		end
		if (ctl.map_rd) begin
			map_rd_q <= map_mem[map_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_wr) begin
			sum_mem[sum_addr] <= sum_wdata;
		end
		if (ctl.sum_rd) begin
			sum_rd_q <= sum_mem[sum_addr];
		end
	end

	assign map_rdata = map_rd_q;
	assign sum_rdata = sum_rd_q;

endmodule

[rtl/bitmap_page_allocator.sv]
// bitmap page allocator top level: request sequencer, counters and config port
//
// One used bit per page frame lives in a 64-bit-wide map memory, and a second
// memory keeps one bit per map word that is set when the word is full; one flag
// per summary row, in flip-flops, marks full rows. After reset the block sweeps
// both memories clear, one map word per cycle, during which in_ready stays
// low; configuration writes are taken throughout. An allocate request passes
// row flag search with summary read, map read, write-back, then the result
// register. A free passes address check with map and summary read,
// write-back, then the result register; a request that fails a check goes
// straight to the result register. The sequencer returns to idle as it loads
// the result. Requests are handled one at a time, a new request is accepted
// while the previous result still waits on the output, and the result stage
// waits for the output register to drain.
module bitmap_page_allocator #(
	parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
	parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [47:0] page_address,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [47:0] allocated_address,
	output logic [27:0] free_bytes,
	output logic [15:0] used_count,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int MAP_WORDS = (PAGE_COUNT + 63) / 64;
	localparam int SUM_ROWS  = (MAP_WORDS + 63) / 64;
	localparam int MAP_AW    = bpa_pkg::addr_bits(MAP_WORDS);
	localparam int SUM_AW    = bpa_pkg::addr_bits(SUM_ROWS);
	localparam int WW        = SUM_AW + 6;
	localparam int IDX_W     = WW + 6;
	localparam int U_W       = $clog2(PAGE_COUNT + 1);
	localparam int LIMX      = (U_W > 16) ? U_W : 16;
	localparam int FB_W      = U_W + PAGE_SHIFT;
	localparam int FBX       = (FB_W > 28) ? FB_W : 28;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_AROW  = 8'b0000_0100,
		S_AWORD = 8'b0000_1000,
		S_ABIT  = 8'b0001_0000,
		S_FCHK  = 8'b0010_0000,
		S_FMOD  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [MAP_AW-1:0]    clr_q;
	logic [SUM_ROWS-1:0]  row_full_q;
	logic [U_W-1:0]       used_q;
	logic [15:0]          limit_q;
	logic [46:0]          base_q;
	logic                 out_valid_q;

	logic                 op_q;
	logic [47:0]          req_addr_q;
	logic [SUM_AW-1:0]    row_q;
	logic [5:0]           wpos_q;
	logic [63:0]          sum_data_q;
	logic [1:0]           res_status_q;
	logic [47:0]          res_addr_q;
	logic [1:0]           status_q;
	logic [47:0]          alloc_addr_q;
	logic [27:0]          free_bytes_q;
	logic [15:0]          used_count_q;

	bpa_pkg::mem_ctl_t    ctl;
	logic [MAP_AW-1:0]    map_addr;
	logic [63:0]          map_wdata;
	logic [63:0]          map_rdata;
	logic [SUM_AW-1:0]    sum_addr;
	logic [63:0]          sum_wdata;
	logic [63:0]          sum_rdata;

	logic [U_W-1:0]       lim;
	logic                 row_found;
	logic [SUM_AW-1:0]    row_sel;
	logic [5:0]           zpos_w;
	logic [WW-1:0]        word_cand;
	logic                 word_ok;
	logic [5:0]           zpos_b;
	logic [IDX_W-1:0]     alloc_idx;
	logic                 alloc_ok;
	logic [63:0]          map_set;
	logic                 map_full;
	logic [63:0]          sum_set;
	logic [47:0]          alloc_addr;
	logic                 below_base;
	logic [47:0]          fdiff;
	logic [47:0]          fidx;
	logic                 free_ok;
	logic [MAP_AW-1:0]    fword;
	logic [SUM_AW-1:0]    frow;
	logic [5:0]           fpos;
	logic [5:0]           fbit;
	logic                 bit_set;
	logic [U_W-1:0]       fb_diff;
	logic [FBX-1:0]       fb_wide;
	logic [27:0]          free_bytes_d;
	logic [15:0]          used_count_d;
	logic                 cfg_wr;

	// limit and search logic
	assign lim = (LIMX'(limit_q) > LIMX'(PAGE_COUNT)) ? U_W'(PAGE_COUNT) : U_W'(limit_q);

	always_comb begin
		row_found = 1'b0;
		row_sel   = '0;
		for (int i = SUM_ROWS - 1; i >= 0; i--) begin
			if (!row_full_q[i]) begin
				row_found = 1'b1;
				row_sel   = SUM_AW'(i);
			end
		end
	end

	assign zpos_w    = bpa_pkg::low_zero(sum_rdata);
	assign word_cand = {row_q, zpos_w};
	assign word_ok   = 32'(word_cand) < 32'(MAP_WORDS);

	assign zpos_b     = bpa_pkg::low_zero(map_rdata);
	assign alloc_idx  = {row_q, wpos_q, zpos_b};
	assign alloc_ok   = 32'(alloc_idx) < 32'(lim);
	assign map_set    = map_rdata | (64'd1 << zpos_b);
	assign map_full   = &map_set;
	assign sum_set    = sum_data_q | (64'(map_full) << wpos_q);
	assign alloc_addr = {1'b0, base_q} + (48'(alloc_idx) << PAGE_SHIFT);

	// free address decode
	assign below_base = req_addr_q < {1'b0, base_q};
	assign fdiff      = req_addr_q - {1'b0, base_q};
	assign fidx       = fdiff >> PAGE_SHIFT;
	assign free_ok    = !below_base && (fidx < 48'(lim));
	assign fword      = fidx[MAP_AW+5:6];
	assign frow       = fidx[SUM_AW+11:12];
	assign fpos       = fidx[11:6];
	assign fbit       = fidx[5:0];
	assign bit_set    = map_rdata[fbit];

	// result counters with saturation
	assign fb_diff      = (lim > used_q) ? (lim - used_q) : '0;
	assign fb_wide      = FBX'(fb_diff) << PAGE_SHIFT;
	assign free_bytes_d = (fb_wide > FBX'(bpa_pkg::FREE_MAX)) ? bpa_pkg::FREE_MAX : 28'(fb_wide);
	assign used_count_d = (LIMX'(used_q) > LIMX'(bpa_pkg::USED_MAX)) ?
		bpa_pkg::USED_MAX : 16'(used_q);

	// memory control
	always_comb begin
		ctl       = '0;
		map_addr  = (op_q == bpa_pkg::OP_FREE) ? fword : MAP_AW'({row_q, wpos_q});
		map_wdata = '0;
		sum_addr  = (op_q == bpa_pkg::OP_FREE) ? frow : row_q;
		sum_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				map_addr   = clr_q;
				ctl.map_wr = 1'b1;
				sum_addr   = SUM_AW'(clr_q);
				ctl.sum_wr = 32'(clr_q) < 32'(SUM_ROWS);
			end
			S_AROW: begin
				sum_addr   = row_sel;
				ctl.sum_rd = row_found;
			end
			S_AWORD: begin
				map_addr   = MAP_AW'(word_cand);
				ctl.map_rd = word_ok;
			end
			S_ABIT: begin
				ctl.map_wr = alloc_ok;
				map_wdata  = map_set;
				ctl.sum_wr = alloc_ok && map_full;
				sum_wdata  = sum_set;
			end
			S_FCHK: begin
				ctl.map_rd = free_ok;
				ctl.sum_rd = free_ok;
			end
			S_FMOD: begin
				ctl.map_wr = bit_set;
				map_wdata  = map_rdata & ~(64'd1 << fbit);
				ctl.sum_wr = bit_set;
				sum_wdata  = sum_rdata & ~(64'd1 << fpos);
			end
			S_IDLE, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	bpa_mem #(
		.MAP_WORDS(MAP_WORDS),
		.SUM_ROWS (SUM_ROWS)
	) u_mem (
		.clk      (clk),
		.ctl      (ctl),
		.map_addr (map_addr),
		.map_wdata(map_wdata),
		.map_rdata(map_rdata),
		.sum_addr (sum_addr),
		.sum_wdata(sum_wdata),
		.sum_rdata(sum_rdata)
	);

	assign cfg_wr = psel && penable && pwrite;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			row_full_q  <= '0;
			used_q      <= '0;
			limit_q     <= bpa_pkg::LIMIT_RST;
			base_q      <= bpa_pkg::BASE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[3])
					bpa_pkg::REG_LIMIT: limit_q <= pwdata[15:0];
					bpa_pkg::REG_BASE:  base_q  <= pwdata[46:0];
					default: begin
					end
				endcase
			end
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAP_AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (opcode == bpa_pkg::OP_FREE) ? S_FCHK : S_AROW;
					end
				end
				S_AROW: begin
					state_q <= row_found ? S_AWORD : S_OUT;
				end
				S_AWORD: begin
					state_q <= word_ok ? S_ABIT : S_OUT;
				end
				S_ABIT: begin
					if (alloc_ok) begin
						used_q <= used_q + 1'b1;
						if (map_full) begin
							row_full_q[row_q] <= &sum_set;
						end
					end
					state_q <= S_OUT;
				end
				S_FCHK: begin
					state_q <= free_ok ? S_FMOD : S_OUT;
				end
				S_FMOD: begin
					if (bit_set) begin
						row_full_q[frow] <= 1'b0;
						if (used_q != '0) begin
							used_q <= used_q - 1'b1;
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q       <= opcode;
					req_addr_q <= page_address;
				end
			end
			S_AROW: begin
				row_q <= row_sel;
				if (!row_found) begin
					res_status_q <= bpa_pkg::ST_OOM;
					res_addr_q   <= '0;
				end
			end
			S_AWORD: begin
				wpos_q     <= zpos_w;
				sum_data_q <= sum_rdata;
				if (!word_ok) begin
					res_status_q <= bpa_pkg::ST_OOM;
					res_addr_q   <= '0;
				end
			end
			S_ABIT: begin
				res_status_q <= alloc_ok ? bpa_pkg::ST_DONE : bpa_pkg::ST_OOM;
				res_addr_q   <= alloc_ok ? alloc_addr : '0;
			end
			S_FCHK: begin
				if (!free_ok) begin
					res_status_q <= bpa_pkg::ST_INVALID;
					res_addr_q   <= '0;
				end
			end
			S_FMOD: begin
				res_status_q <= bpa_pkg::ST_DONE;
				res_addr_q   <= '0;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					status_q     <= res_status_q;
					alloc_addr_q <= res_addr_q;
					free_bytes_q <= free_bytes_d;
					used_count_q <= used_count_d;
				end
			end
			S_CLEAR: begin
			end
			default: begin
			end
		endcase
	end

	assign in_ready          = (state_q == S_IDLE);
	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign allocated_address = alloc_addr_q;
	assign free_bytes        = free_bytes_q;
	assign used_count        = used_count_q;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == bpa_pkg::REG_BASE) ? {17'd0, base_q} : {48'd0, limit_q};

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(PAGE_COUNT))
		else $error("used page count above page count");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the result stage");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ABIT && alloc_ok) |=> (used_q == $past(used_q) + 1'b1))
		else $error("allocate did not bump the used count");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == bpa_pkg::ST_DONE || status_q == bpa_pkg::ST_OOM ||
			status_q == bpa_pkg::ST_INVALID))
		else $error("bad status code");

	a_oom_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != bpa_pkg::ST_DONE) |-> (alloc_addr_q == '0))
		else $error("failed request carries an address");

endmodule
